>>> sv/assert_macros.svh
// Assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define PBS_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("pbs check failed");

// next-cycle implication
`define PBS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("pbs check failed");

`endif

>>> sv/pbs_pkg.sv
`timescale 1ns / 1ps

package pbs_pkg;

	localparam int TIME_BITS_DEF = 40;
	localparam int CFG_W         = 20;
	localparam int CFG_IDX_W     = 3;

	localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PRESS    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_HOLD     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ON_WAIT  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_OFF_WAIT = 3'd4;

	localparam logic [CFG_W-1:0] DEBOUNCE_RST = 20'd50;
	localparam logic [CFG_W-1:0] PRESS_RST    = 20'd200;
	localparam logic [CFG_W-1:0] HOLD_RST     = 20'd5000;
	localparam logic [CFG_W-1:0] ON_WAIT_RST  = 20'd10000;
	localparam logic [CFG_W-1:0] OFF_WAIT_RST = 20'd60000;

	localparam logic [1:0] REQ_NONE  = 2'd0;
	localparam logic [1:0] REQ_PRESS = 2'd1;
	localparam logic [1:0] REQ_HOLD  = 2'd2;

	typedef enum logic [2:0] {
		MODE_UNKNOWN  = 3'd0,
		MODE_OFF      = 3'd1,
		MODE_ON       = 3'd2,
		MODE_TURN_ON  = 3'd3,
		MODE_TURN_OFF = 3'd4
	} mode_t;

	typedef struct packed {
		logic [CFG_W-1:0] debounce_time;
		logic [CFG_W-1:0] press_width;
		logic [CFG_W-1:0] hold_width;
		logic [CFG_W-1:0] on_wait;
		logic [CFG_W-1:0] off_wait;
	} cfg_t;

	typedef struct packed {
		logic       request_ok;
		logic       button_drive;
		mode_t      power_mode;
		logic [1:0] pending_type;
	} status_t;

endpackage

>>> sv/pbs_fsm.sv
`timescale 1ns / 1ps

module pbs_fsm import pbs_pkg::*; #(
	parameter int TIME_BITS = TIME_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 fire,
	input  cfg_t                 cfg,
	input  logic                 kind,
	input  logic                 sense_in,
	input  logic [1:0]           request_type,
	input  logic [TIME_BITS-1:0] time_now,
	output status_t              status_n,
	output logic [TIME_BITS-1:0] mode_since_n
);

	localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};

	mode_t                mode_q, mode_n;
	logic [TIME_BITS-1:0] entered_q, entered_n;
	logic                 raw_q, raw_n;
	logic [TIME_BITS-1:0] raw_chg_q, raw_chg_n;
	logic                 bel_q, bel_n;
	logic                 belv_q, belv_n;
	logic                 pulse_q, pulse_n;
	logic [TIME_BITS-1:0] pulse_end_q, pulse_end_n;
	logic [1:0]           pend_q, pend_n;
	logic [TIME_BITS-1:0] dl_q, dl_n;

	logic [TIME_BITS-1:0] elapsed;
	logic                 deb_ok;
	logic                 req_ok;
	logic [CFG_W-1:0]     width;
	logic [CFG_W-1:0]     wait_ms;
	logic [TIME_BITS:0]   end_sum;
	logic [TIME_BITS+1:0] dl_sum;
	logic [TIME_BITS-1:0] end_sat;
	logic [TIME_BITS-1:0] dl_sat;
	mode_t                tgt;
	logic                 finish;

	assign elapsed = time_now - raw_chg_q;
	assign deb_ok  = (sense_in == raw_q) && (elapsed >= TIME_BITS'(cfg.debounce_time));

	assign req_ok = ((request_type == REQ_PRESS) || (request_type == REQ_HOLD)) && !pulse_q
		&& ((mode_q == MODE_OFF) || (mode_q == MODE_ON));
	assign width   = (request_type == REQ_HOLD) ? cfg.hold_width : cfg.press_width;
	assign wait_ms = (mode_q == MODE_OFF) ? cfg.on_wait : cfg.off_wait;
	// one three-input add saturates the same as two chained saturating adds
	assign end_sum = {1'b0, time_now} + (TIME_BITS+1)'(width);
	assign dl_sum  = {2'b00, time_now} + (TIME_BITS+2)'(width) + (TIME_BITS+2)'(wait_ms);
	assign end_sat = end_sum[TIME_BITS] ? TIME_MAX : end_sum[TIME_BITS-1:0];
	assign dl_sat  = (dl_sum[TIME_BITS+1:TIME_BITS] != 2'b00) ? TIME_MAX
		: dl_sum[TIME_BITS-1:0];

	always_comb begin
		raw_n       = raw_q;
		raw_chg_n   = raw_chg_q;
		bel_n       = bel_q;
		belv_n      = belv_q;
		pulse_n     = pulse_q;
		pulse_end_n = pulse_end_q;
		pend_n      = pend_q;
		dl_n        = dl_q;
		tgt         = mode_q;
		finish      = 1'b0;
		if (!kind) begin
			if (sense_in != raw_q) begin
				raw_n     = sense_in;
				raw_chg_n = time_now;
			end else if (deb_ok) begin
				bel_n  = sense_in;
				belv_n = 1'b1;
			end
			if (pulse_q && (time_now >= pulse_end_q))
				pulse_n = 1'b0;
			if (belv_n) begin
				case (mode_q)
					MODE_UNKNOWN: tgt = bel_n ? MODE_ON : MODE_OFF;
					MODE_OFF: if (bel_n) tgt = MODE_ON;
					MODE_ON: if (!bel_n) tgt = MODE_OFF;
					MODE_TURN_ON: begin
						if (bel_n) begin
							tgt    = MODE_ON;
							finish = 1'b1;
						end else if (time_now >= dl_q) begin
							tgt    = MODE_OFF;
							finish = 1'b1;
						end
					end
					MODE_TURN_OFF: begin
						if (!bel_n) begin
							tgt    = MODE_OFF;
							finish = 1'b1;
						end else if (time_now >= dl_q) begin
							tgt    = MODE_ON;
							finish = 1'b1;
						end
					end
					default: tgt = mode_q;
				endcase
			end
			if (finish) begin
				pend_n = REQ_NONE;
				dl_n   = '0;
			end
		end else if (req_ok) begin
			pend_n      = request_type;
			pulse_n     = 1'b1;
			pulse_end_n = end_sat;
			dl_n        = dl_sat;
			tgt         = (mode_q == MODE_OFF) ? MODE_TURN_ON : MODE_TURN_OFF;
		end
		mode_n    = tgt;
		entered_n = (tgt != mode_q) ? time_now : entered_q;
	end

	assign status_n.request_ok   = kind && req_ok;
	assign status_n.button_drive = pulse_n;
	assign status_n.power_mode   = mode_n;
	assign status_n.pending_type = pend_n;
	assign mode_since_n          = entered_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= MODE_UNKNOWN;
			entered_q   <= '0;
			raw_q       <= 1'b0;
			raw_chg_q   <= '0;
			bel_q       <= 1'b0;
			belv_q      <= 1'b0;
			pulse_q     <= 1'b0;
			pulse_end_q <= '0;
			pend_q      <= REQ_NONE;
			dl_q        <= '0;
		end else if (fire) begin
			mode_q      <= mode_n;
			entered_q   <= entered_n;
			raw_q       <= raw_n;
			raw_chg_q   <= raw_chg_n;
			bel_q       <= bel_n;
			belv_q      <= belv_n;
			pulse_q     <= pulse_n;
			pulse_end_q <= pulse_end_n;
			pend_q      <= pend_n;
			dl_q        <= dl_n;
		end
	end

endmodule

>>> sv/power_button_sequencer.sv
`timescale 1ns / 1ps
// A word accepted into the input register moves on to the output register once the output is not stalled.
// Throughput: one word per cycle while out_stall does not hold the output; the whole update of the
// sequencer state is one registered step between the input register and the output register.
// Reset (arst_n low, asynchronous): pipeline empty, power mode unknown, no pulse,
// timing registers back to their default values.

module power_button_sequencer import pbs_pkg::*; #(
	parameter int TIME_BITS = TIME_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wr,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic                 kind,
	input  logic                 sense_in,
	input  logic [1:0]           request_type,
	input  logic [TIME_BITS-1:0] time_now,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic                 request_ok,
	output logic                 button_drive,
	output logic [2:0]           power_mode,
	output logic [TIME_BITS-1:0] mode_since,
	output logic [1:0]           pending_type
);

	cfg_t                 cfg_q;
	logic                 v_s1;
	logic                 kind_s1;
	logic                 sense_s1;
	logic [1:0]           req_s1;
	logic [TIME_BITS-1:0] time_s1;
	logic                 v_s2;
	status_t              stat_s2;
	logic [TIME_BITS-1:0] since_s2;
	status_t              status_n;
	logic [TIME_BITS-1:0] mode_since_n;
	logic                 advance;
	logic                 fire;

	assign advance  = !v_s2 || !out_stall;
	assign fire     = v_s1 && advance;
	assign in_stall = v_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_time <= DEBOUNCE_RST;
			cfg_q.press_width   <= PRESS_RST;
			cfg_q.hold_width    <= HOLD_RST;
			cfg_q.on_wait       <= ON_WAIT_RST;
			cfg_q.off_wait      <= OFF_WAIT_RST;
		end else if (cfg_wr) begin
			case (cfg_index)
				REG_DEBOUNCE: cfg_q.debounce_time <= cfg_data;
				REG_PRESS:    cfg_q.press_width   <= cfg_data;
				REG_HOLD:     cfg_q.hold_width    <= cfg_data;
				REG_ON_WAIT:  cfg_q.on_wait       <= cfg_data;
				REG_OFF_WAIT: cfg_q.off_wait      <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (!in_stall)
				v_s1 <= in_valid;
			if (advance)
				v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			kind_s1  <= kind;
			sense_s1 <= sense_in;
			req_s1   <= request_type;
			time_s1  <= time_now;
		end
		if (fire) begin
			stat_s2  <= status_n;
			since_s2 <= mode_since_n;
		end
	end

	pbs_fsm #(
		.TIME_BITS(TIME_BITS)
	) u_fsm (
		.clk          (clk),
		.arst_n       (arst_n),
		.fire         (fire),
		.cfg          (cfg_q),
		.kind         (kind_s1),
		.sense_in     (sense_s1),
		.request_type (req_s1),
		.time_now     (time_s1),
		.status_n     (status_n),
		.mode_since_n (mode_since_n)
	);

	assign out_valid    = v_s2;
	assign request_ok   = stat_s2.request_ok;
	assign button_drive = stat_s2.button_drive;
	assign power_mode   = stat_s2.power_mode;
	assign mode_since   = since_s2;
	assign pending_type = stat_s2.pending_type;

endmodule

>>> sv/pbs_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module pbs_checker import pbs_pkg::*; #(
	parameter int TIME_BITS = TIME_BITS_DEF
) (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 out_valid,
	input logic                 out_stall,
	input logic                 request_ok,
	input logic                 button_drive,
	input logic [2:0]           power_mode,
	input logic [TIME_BITS-1:0] mode_since,
	input logic [1:0]           pending_type
);

	// a stalled word stays and holds its payload
	`PBS_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable({request_ok, button_drive, power_mode, mode_since, pending_type}))

	// an accepted request starts the pulse and records what is pending
	`PBS_ASSERT_NOW(a_ok_pulse, clk, arst_n, out_valid && request_ok, button_drive && (pending_type != REQ_NONE))

	// a pending request only lives in a turning mode
	`PBS_ASSERT_NOW(a_pend_turn, clk, arst_n, out_valid && (pending_type != REQ_NONE), (power_mode == MODE_TURN_ON) || (power_mode == MODE_TURN_OFF))

	// a turning mode always has its request pending
	`PBS_ASSERT_NOW(a_turn_pend, clk, arst_n, out_valid && ((power_mode == MODE_TURN_ON) || (power_mode == MODE_TURN_OFF)), pending_type != REQ_NONE)

endmodule

bind power_button_sequencer pbs_checker #(
	.TIME_BITS(TIME_BITS)
) u_pbs_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.request_ok   (request_ok),
	.button_drive (button_drive),
	.power_mode   (power_mode),
	.mode_since   (mode_since),
	.pending_type (pending_type)
);

>>> tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
	import pbs_pkg::*;

	localparam int TW = TIME_BITS_DEF;
	localparam int CYCLE_LIMIT = 400000;
	localparam logic [TW-1:0] TIME_MAX = {TW{1'b1}};

	typedef struct packed {
		logic             ok;
		logic             drive;
		mode_t            mode;
		logic [TW-1:0]    since;
		logic [1:0]       pend;
	} status_word_t;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cfg_wr;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;
	logic                 in_valid;
	logic                 in_stall;
	logic                 kind;
	logic                 sense_in;
	logic [1:0]           request_type;
	logic [TW-1:0]        time_now;
	logic                 out_valid;
	logic                 out_stall;
	logic                 request_ok;
	logic                 button_drive;
	logic [2:0]           power_mode;
	logic [TW-1:0]        mode_since;
	logic [1:0]           pending_type;

	power_button_sequencer #(.TIME_BITS(TW)) u_top (
		.clk(clk), .arst_n(arst_n),
		.cfg_wr(cfg_wr), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.kind(kind), .sense_in(sense_in), .request_type(request_type), .time_now(time_now),
		.out_valid(out_valid), .out_stall(out_stall),
		.request_ok(request_ok), .button_drive(button_drive), .power_mode(power_mode),
		.mode_since(mode_since), .pending_type(pending_type)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// mirror of the sequencer
	cfg_t          cfg_mirror;
	mode_t         mode_now;
	logic [TW-1:0] since_now;
	logic          raw_lvl;
	logic [TW-1:0] raw_at;
	logic          led_lvl;
	logic          led_known;
	logic          pulse_on;
	logic [TW-1:0] pulse_stop;
	logic [1:0]    pend_now;
	logic [TW-1:0] give_up_at;

	status_word_t  status_due[$];

	int  mismatches = 0;
	int  words_sent = 0;
	int  words_checked = 0;
	int  req_taken = 0;
	int  req_refused = 0;
	int  reg_writes = 0;
	int  cycles = 0;
	bit  in_gaps = 1'b0;
	bit  rx_gaps = 1'b0;
	int  hold_reqs = 0;
	logic [TW-1:0] now_ms;
	logic          led_wire;

	function automatic logic [TW-1:0] add_clamped(logic [TW-1:0] a, logic [CFG_W-1:0] b);
		logic [TW:0] s;
		s = {1'b0, a} + b;
		return s[TW] ? TIME_MAX : s[TW-1:0];
	endfunction

	task automatic enter_mode(input mode_t m, input logic [TW-1:0] t);
		if (mode_now != m) begin
			mode_now = m;
			since_now = t;
		end
	endtask

	task automatic close_turn(input mode_t m, input logic [TW-1:0] t);
		pend_now = REQ_NONE;
		give_up_at = '0;
		enter_mode(m, t);
	endtask

	task automatic sequencer_step(input logic k, input logic s, input logic [1:0] r,
			input logic [TW-1:0] t);
		status_word_t     w;
		logic [TW-1:0]    held;
		logic [CFG_W-1:0] width;
		w = '0;
		if (!k) begin
			held = t - raw_at;
			if (s != raw_lvl) begin
				raw_lvl = s;
				raw_at = t;
			end else if (held >= cfg_mirror.debounce_time) begin
				led_lvl = s;
				led_known = 1'b1;
			end
			if (pulse_on && t >= pulse_stop)
				pulse_on = 1'b0;
			if (led_known) begin
				case (mode_now)
					MODE_UNKNOWN: enter_mode(led_lvl ? MODE_ON : MODE_OFF, t);
					MODE_OFF: if (led_lvl) enter_mode(MODE_ON, t);
					MODE_ON: if (!led_lvl) enter_mode(MODE_OFF, t);
					MODE_TURN_ON: begin
						if (led_lvl)
							close_turn(MODE_ON, t);
						else if (t >= give_up_at)
							close_turn(MODE_OFF, t);
					end
					MODE_TURN_OFF: begin
						if (!led_lvl)
							close_turn(MODE_OFF, t);
						else if (t >= give_up_at)
							close_turn(MODE_ON, t);
					end
					default: ;
				endcase
			end
		end else if ((r == REQ_PRESS || r == REQ_HOLD) && !pulse_on &&
				(mode_now == MODE_OFF || mode_now == MODE_ON)) begin
			w.ok = 1'b1;
			width = (r == REQ_HOLD) ? cfg_mirror.hold_width : cfg_mirror.press_width;
			pend_now = r;
			pulse_on = 1'b1;
			pulse_stop = add_clamped(t, width);
			if (mode_now == MODE_OFF) begin
				enter_mode(MODE_TURN_ON, t);
				give_up_at = add_clamped(pulse_stop, cfg_mirror.on_wait);
			end else begin
				enter_mode(MODE_TURN_OFF, t);
				give_up_at = add_clamped(pulse_stop, cfg_mirror.off_wait);
			end
		end
		if (k) begin
			if (w.ok)
				req_taken++;
			else
				req_refused++;
		end
		w.drive = pulse_on;
		w.mode = mode_now;
		w.since = since_now;
		w.pend = pend_now;
		status_due.push_back(w);
	endtask

	// called at a falling edge with in_valid low; returns the same way
	task automatic send_word(input logic k, input logic s, input logic [1:0] r,
			input logic [TW-1:0] t);
		if (in_gaps && $urandom_range(0, 3) == 0)
			repeat ($urandom_range(1, 8)) @(negedge clk);
		in_valid = 1'b1;
		kind = k;
		sense_in = s;
		request_type = r;
		time_now = t;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sequencer_step(k, s, r, t);
		words_sent++;
		@(negedge clk);
		in_valid = 1'b0;
	endtask

	task automatic sample_at(input logic lvl, input int dt);
		now_ms = now_ms + dt;
		send_word(1'b0, lvl, 2'($urandom_range(0, 3)), now_ms);
	endtask

	task automatic button_at(input logic [1:0] r, input int dt);
		now_ms = now_ms + dt;
		send_word(1'b1, 1'($urandom), r, now_ms);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		cfg_wr = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		@(posedge clk);
		case (idx)
			REG_DEBOUNCE: cfg_mirror.debounce_time = val;
			REG_PRESS:    cfg_mirror.press_width = val;
			REG_HOLD:     cfg_mirror.hold_width = val;
			REG_ON_WAIT:  cfg_mirror.on_wait = val;
			REG_OFF_WAIT: cfg_mirror.off_wait = val;
			default: ;
		endcase
		reg_writes++;
		@(negedge clk);
		cfg_wr = 1'b0;
	endtask

	task automatic write_all(input logic [CFG_W-1:0] deb, input logic [CFG_W-1:0] prs,
			input logic [CFG_W-1:0] hld, input logic [CFG_W-1:0] onw,
			input logic [CFG_W-1:0] offw);
		write_reg(REG_DEBOUNCE, deb);
		write_reg(REG_PRESS, prs);
		write_reg(REG_HOLD, hld);
		write_reg(REG_ON_WAIT, onw);
		write_reg(REG_OFF_WAIT, offw);
	endtask

	task automatic drain_all();
		while (status_due.size() != 0)
			@(negedge clk);
		repeat (6) @(negedge clk);
	endtask

	// default timings straight out of reset
	task automatic test_default_flow();
		now_ms = '0;
		button_at(REQ_PRESS, 0);     // mode still unknown: refused
		sample_at(1'b0, 0);
		sample_at(1'b0, 60);         // believed low -> off
		button_at(REQ_NONE, 1);
		button_at(2'd3, 1);
		button_at(REQ_HOLD, 8);      // hold from off is a turn-on
		button_at(REQ_PRESS, 10);    // pulse busy
		sample_at(1'b1, 20);
		sample_at(1'b1, 60);         // confirmed on, pulse still running
		button_at(REQ_PRESS, 4940);  // pulse over but no sample yet: refused
		sample_at(1'b1, 0);          // pulse clears, on kept with old since
		button_at(REQ_PRESS, 100);
		sample_at(1'b1, 300);
		sample_at(1'b1, 64500);      // off never sensed: back to on
		button_at(REQ_PRESS, 10);
		sample_at(1'b0, 290);
		sample_at(1'b0, 100);        // confirmed off
	endtask

	task automatic test_register_extremes();
		drain_all();
		write_all('0, '0, '0, '0, '0);
		write_reg(3'd5, '1);         // no such register
		write_reg(3'd7, '1);
		sample_at(1'b1, 5);
		sample_at(1'b1, 0);
		button_at(REQ_PRESS, 0);     // zero width pulse
		sample_at(1'b1, 0);
		sample_at(1'b0, 3);
		now_ms = now_ms - 2;
		sample_at(1'b0, 0);          // time going backwards
		drain_all();
		write_all('1, '1, '1, '1, '1);
		now_ms = TIME_MAX - 40'd2000000;
		sample_at(1'b0, 0);
		sample_at(1'b1, 0);
		sample_at(1'b1, 1500000);
		button_at(REQ_HOLD, 0);      // end and deadline clamp at the top
		sample_at(1'b1, 499999);
		sample_at(1'b1, 1);          // time at all ones
		drain_all();
	endtask

	task automatic run_session(input int count);
		int pick;
		int back;
		for (int i = 0; i < count; i++) begin
			pick = $urandom_range(0, 99);
			if (mode_now == MODE_TURN_ON && $urandom_range(0, 9) < 3)
				led_wire = 1'b1;
			else if (mode_now == MODE_TURN_OFF && $urandom_range(0, 9) < 3)
				led_wire = 1'b0;
			else if ($urandom_range(0, 49) == 0)
				led_wire = !led_wire;
			if (pick < 3) begin
				button_at($urandom_range(0, 1) ? REQ_NONE : 2'd3, $urandom_range(0, 5));
			end else if (pick < 6) begin
				sample_at(!led_wire, $urandom_range(0, 3));
			end else if (pick < 8) begin
				back = $urandom_range(1, 20);
				if (now_ms > back)
					now_ms = now_ms - back;
				sample_at(led_wire, 0);
			end else if (pick < 28) begin
				button_at($urandom_range(0, 1) ? REQ_HOLD : REQ_PRESS, $urandom_range(0, 6));
			end else if (pick < 33) begin
				sample_at(led_wire, $urandom_range(0, 300));
			end else begin
				sample_at(led_wire, $urandom_range(0, 12));
			end
		end
	endtask

	task automatic test_random_sessions(input int sessions, input int count);
		for (int n = 0; n < sessions; n++) begin
			drain_all();
			write_all(CFG_W'($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 15)),
				CFG_W'($urandom_range(0, 40)), CFG_W'($urandom_range(20, 120)),
				CFG_W'($urandom_range(0, 200)), CFG_W'($urandom_range(0, 300)));
			if (n == 2)
				now_ms = TIME_MAX - 40'd3000000 - $urandom_range(0, 1000000);
			run_session(count);
		end
	endtask

	task automatic test_backpressure();
		drain_all();
		hold_reqs++;                 // receiver holds off for a long stretch
		run_session(40);             // fills the pipe and stalls the input
		drain_all();
		run_session(30);
		drain_all();                 // sender waits out every result
		run_session(30);
	endtask

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb_top NOT OK");
			$finish;
		end
	end

	task automatic check_field(input string name, input logic [TW-1:0] exp_v,
			input logic [TW-1:0] act_v);
		if (exp_v !== act_v) begin
			$error("%s: expected %0h, got %0h", name, exp_v, act_v);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin
		status_word_t w;
		if (arst_n && out_valid && !out_stall) begin
			if (status_due.size() == 0) begin
				$error("result word with nothing expected");
				mismatches++;
			end else begin
				w = status_due.pop_front();
				words_checked++;
				check_field("request_ok", TW'(w.ok), TW'(request_ok));
				check_field("button_drive", TW'(w.drive), TW'(button_drive));
				check_field("power_mode", TW'(w.mode), TW'(power_mode));
				check_field("mode_since", w.since, mode_since);
				check_field("pending_type", TW'(w.pend), TW'(pending_type));
			end
		end
	end

	// receiver: random stall bursts plus a long hold on request
	initial begin
		int burst;
		int hold_left;
		int hold_seen;
		burst = 0;
		hold_left = 0;
		hold_seen = 0;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_seen != hold_reqs) begin
				hold_seen = hold_reqs;
				hold_left = 300;
			end
			if (hold_left > 0) begin
				out_stall = 1'b1;
				hold_left--;
			end else if (burst > 0) begin
				out_stall = 1'b1;
				burst--;
			end else if (rx_gaps && $urandom_range(0, 5) == 0) begin
				out_stall = 1'b1;
				burst = $urandom_range(0, 7);
			end else begin
				out_stall = 1'b0;
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_wr = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		kind = 1'b0;
		sense_in = 1'b0;
		request_type = REQ_NONE;
		time_now = '0;
		now_ms = '0;
		led_wire = 1'b0;
		cfg_mirror = '{DEBOUNCE_RST, PRESS_RST, HOLD_RST, ON_WAIT_RST, OFF_WAIT_RST};
		mode_now = MODE_UNKNOWN;
		since_now = '0;
		raw_lvl = 1'b0;
		raw_at = '0;
		led_lvl = 1'b0;
		led_known = 1'b0;
		pulse_on = 1'b0;
		pulse_stop = '0;
		pend_now = REQ_NONE;
		give_up_at = '0;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_default_flow();
		test_register_extremes();
		in_gaps = 1'b1;
		rx_gaps = 1'b1;
		test_random_sessions(6, 180);
		test_backpressure();
		drain_all();
		in_gaps = 1'b0;
		rx_gaps = 1'b0;
		test_random_sessions(1, 150);

		drain_all();
		repeat (10) @(negedge clk);
		$display("run covered %0d words (%0d requests taken, %0d refused), %0d register writes",
			words_sent, req_taken, req_refused, reg_writes);
		$display("%0d result words compared, %0d mismatches", words_checked, mismatches);
		if (mismatches == 0 && status_due.size() == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end

endmodule
